>>> hdl/ipbt_pkg.sv
// ----------------------------------------------------------------------------
// IP prefix ban table package
// Shared types, codes and a helper function of the prefix ban table.
// ----------------------------------------------------------------------------
package ipbt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned PLEN_W      = 6;
  localparam int unsigned HITS_W      = 32;

  localparam logic [PLEN_W-1:0] MIN_PREFIX_RESET = 6'd16;
  localparam logic [PLEN_W-1:0] MAX_PREFIX       = 6'd32;
  localparam logic [CNT_W-1:0]  DEPTH_CNT        = CNT_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    ACT_CHECK = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_DEL   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISS    = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PLEN_W-1:0] prefix;
    logic [HITS_W-1:0] hits;
  } entry_t;

  // Network mask for a prefix length; lengths above 32 give a full mask.
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] mask;
    if (plen == '0) begin
      mask = '0;
    end else if (plen >= MAX_PREFIX) begin
      mask = '1;
    end else begin
      mask = ~({ADDR_W{1'b1}} >> plen);
    end
    return mask;
  endfunction

endpackage

>>> hdl/ipbt_if.sv
// ----------------------------------------------------------------------------
// IP prefix ban table channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface ipbt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] address;
  logic [5:0]  prefix_len;

  modport source (output valid, action, address, prefix_len, input ready);
  modport sink   (input valid, action, address, prefix_len, output ready);
endinterface

interface ipbt_rsp_if;
  logic        valid;
  logic        ready;
  logic        matched;
  logic [1:0]  status;
  logic [31:0] hit_count;
  logic [6:0]  entry_count;

  modport source (output valid, matched, status, hit_count, entry_count, input ready);
  modport sink   (input valid, matched, status, hit_count, entry_count, output ready);
endinterface

>>> hdl/ip_prefix_ban_table.sv
// ----------------------------------------------------------------------------
// IP prefix ban table
// Ordered IPv4 prefix ban list with hit counters, held in one on-chip memory.
// ----------------------------------------------------------------------------
// The block handles one item at a time. The bans live in a single memory with
// one write port and one read port with registered read data, so every table
// walk runs at one entry per cycle. A check, add or delete scans the stored
// bans in insertion order, stopping early at the first hit. A delete that finds
// its ban then moves every later ban down by one. A rejected add or delete and
// a clear skip the walk. The result then moves into the output register; the
// response state waits while an older result there is still stalled, and the
// block then returns to idle to take the next item. A new item is taken as soon
// as the previous one has moved its result into the output register, even while
// that result still waits there. The minimum prefix length register is written
// through cfg_we_i and cfg_wdata_i and must only change while the block is idle.
// ----------------------------------------------------------------------------
module ip_prefix_ban_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ipbt_req_if.sink             req,
  ipbt_rsp_if.source           rsp,
  input  logic                 cfg_we_i,
  input  logic [ipbt_pkg::PLEN_W-1:0] cfg_wdata_i
);
  import ipbt_pkg::*;

  // Ban storage: address, prefix length and hit counter of each entry.
  entry_t mem [TABLE_DEPTH];
  entry_t mem_rdata_q;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  state_e state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic [PLEN_W-1:0] min_q;

  // The item being worked on.
  action_e           act_q, act_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [PLEN_W-1:0] plen_q, plen_d;

  // Result waiting to move into the output register.
  logic              res_matched_q, res_matched_d;
  status_e           res_status_q, res_status_d;
  logic [HITS_W-1:0] res_hits_q, res_hits_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic              out_matched_q, out_matched_d;
  logic [1:0]        out_status_q, out_status_d;
  logic [HITS_W-1:0] out_hits_q, out_hits_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;

  logic              req_fire;
  logic              ban_ok;
  logic [ADDR_W-1:0] rd_mask;
  logic              hit;
  logic [HITS_W-1:0] hits_inc;

  assign req.ready = (state_q == ST_IDLE);
  assign req_fire  = req.valid && req.ready;

  // A ban is usable when the address is nonzero and the prefix length lies
  // between the configured minimum (and one) and 32.
  assign ban_ok = (req.address != '0) && (req.prefix_len != '0)
               && (req.prefix_len <= MAX_PREFIX) && (req.prefix_len >= min_q);

  // Compare the entry that just came out of the memory against the item.
  assign rd_mask  = prefix_mask(mem_rdata_q.prefix);
  assign hit      = rd_vld_q && ((act_q == ACT_CHECK)
                  ? ((addr_q & rd_mask) == (mem_rdata_q.addr & rd_mask))
                  : ((mem_rdata_q.addr == addr_q) && (mem_rdata_q.prefix == plen_q)));
  assign hits_inc = (mem_rdata_q.hits == '1) ? mem_rdata_q.hits : mem_rdata_q.hits + 1'b1;

  assign rsp.valid       = out_valid_q;
  assign rsp.matched     = out_matched_q;
  assign rsp.status      = out_status_q;
  assign rsp.hit_count   = out_hits_q;
  assign rsp.entry_count = out_count_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      min_q       <= MIN_PREFIX_RESET;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q      <= rd_idx_d;
    cmp_idx_q     <= cmp_idx_d;
    act_q         <= act_d;
    addr_q        <= addr_d;
    plen_q        <= plen_d;
    res_matched_q <= res_matched_d;
    res_status_q  <= res_status_d;
    res_hits_q    <= res_hits_d;
    out_matched_q <= out_matched_d;
    out_status_q  <= out_status_d;
    out_hits_q    <= out_hits_d;
    out_count_q   <= out_count_d;
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    rd_idx_d      = rd_idx_q;
    rd_vld_d      = 1'b0;
    cmp_idx_d     = cmp_idx_q;
    act_d         = act_q;
    addr_d        = addr_q;
    plen_d        = plen_q;
    res_matched_d = res_matched_q;
    res_status_d  = res_status_q;
    res_hits_d    = res_hits_q;
    out_valid_d   = out_valid_q && !rsp.ready;
    out_matched_d = out_matched_q;
    out_status_d  = out_status_q;
    out_hits_d    = out_hits_q;
    out_count_d   = out_count_q;
    mem_re        = 1'b0;
    mem_raddr     = rd_idx_q[IDX_W-1:0];
    mem_we        = 1'b0;
    mem_waddr     = cmp_idx_q;
    mem_wdata     = mem_rdata_q;

    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          act_d         = action_e'(req.action);
          addr_d        = req.address;
          plen_d        = req.prefix_len;
          rd_idx_d      = '0;
          res_matched_d = 1'b0;
          res_status_d  = STAT_OK;
          res_hits_d    = '0;
          case (action_e'(req.action))
            ACT_CHECK: begin
              state_d = ST_SCAN;
            end
            ACT_ADD, ACT_DEL: begin
              if (ban_ok) begin
                state_d = ST_SCAN;
              end else begin
                res_status_d = STAT_INVALID;
                state_d      = ST_RESP;
              end
            end
            default: begin
              count_d = '0;
              state_d = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (hit) begin
          case (act_q)
            ACT_CHECK: begin
              mem_we        = 1'b1;
              mem_wdata     = '{addr: mem_rdata_q.addr, prefix: mem_rdata_q.prefix,
                                hits: hits_inc};
              res_matched_d = 1'b1;
              res_hits_d    = hits_inc;
              state_d       = ST_RESP;
            end
            ACT_DEL: begin
              // Restart the reads just past the ban to close the gap.
              rd_idx_d = {1'b0, cmp_idx_q} + 1'b1;
              state_d  = ST_SHIFT;
            end
            default: begin
              res_status_d = STAT_MISS;
              state_d      = ST_RESP;
            end
          endcase
        end else if (rd_idx_q < count_q) begin
          mem_re    = 1'b1;
          rd_vld_d  = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end else if (!rd_vld_q) begin
          // Walk finished without a hit.
          state_d = ST_RESP;
          case (act_q)
            ACT_ADD: begin
              if (count_q >= DEPTH_CNT) begin
                res_status_d = STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[IDX_W-1:0];
                mem_wdata = '{addr: addr_q, prefix: plen_q, hits: '0};
                count_d   = count_q + 1'b1;
              end
            end
            ACT_DEL: begin
              res_status_d = STAT_MISS;
            end
            default: begin
              res_status_d = STAT_OK;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // Each entry read here is written one place lower in the following cycle.
        if (rd_vld_q) begin
          mem_we    = 1'b1;
          mem_waddr = cmp_idx_q - 1'b1;
        end
        if (rd_idx_q < count_q) begin
          mem_re    = 1'b1;
          rd_vld_d  = 1'b1;
          cmp_idx_d = rd_idx_q[IDX_W-1:0];
          rd_idx_d  = rd_idx_q + 1'b1;
        end else if (!rd_vld_q) begin
          count_d = count_q - 1'b1;
          state_d = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d   = 1'b1;
          out_matched_d = res_matched_q;
          out_status_d  = res_status_q;
          out_hits_d    = res_hits_q;
          out_count_d   = count_q;
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/ipbt_checker.sv
// ----------------------------------------------------------------------------
// IP prefix ban table checker
// Port-level assertions on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module ipbt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic        rsp_matched_i,
  input logic [1:0]  rsp_status_i,
  input logic [31:0] rsp_hit_count_i,
  input logic [6:0]  rsp_entry_count_i
);
  import ipbt_pkg::*;

  // A stalled response keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_hit_count_i)
      && $stable(rsp_entry_count_i) && $stable(rsp_status_i) && $stable(rsp_matched_i))
    else $error("response changed while stalled");

  // The table never holds more bans than it has room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_entry_count_i <= DEPTH_CNT)
    else $error("entry count beyond table depth");

  // A match always reports success and a counter of at least one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_matched_i |-> rsp_status_i == STAT_OK && rsp_hit_count_i != '0)
    else $error("match with bad status or zero counter");

  // Without a match the counter reads zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_matched_i |-> rsp_hit_count_i == '0)
    else $error("nonzero counter without a match");

endmodule

bind ip_prefix_ban_table ipbt_checker u_ipbt_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp.valid),
  .rsp_ready_i       (rsp.ready),
  .rsp_matched_i     (rsp.matched),
  .rsp_status_i      (rsp.status),
  .rsp_hit_count_i   (rsp.hit_count),
  .rsp_entry_count_i (rsp.entry_count)
);
